>>> hw/rtl/dvaw_pkg.sv
`timescale 1ns / 1ps

package dvaw_pkg;

    // default geometry widths
    localparam int DIM_BITS_DEF    = 10;
    localparam int KERNEL_BITS_DEF = 4;
    localparam int ADDR_BITS_DEF   = 40;

    // fixed field widths
    localparam int PAD_BITS  = 8;
    localparam int STEP_BITS = 4;

    // input channel: start_req at bit 0, padded to a byte
    localparam int S_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    // saturating product passes: channels, three kernel sizes, three grid sizes
    localparam int GEOM_STEPS = 7;

    // register map, index order
    typedef enum logic [2:0] {
        REG_CHANNELS = 3'd0,
        REG_VOL_DIMS = 3'd1,
        REG_COL_DIMS = 3'd2,
        REG_KERNEL   = 3'd3,
        REG_PAD      = 3'd4,
        REG_STRIDE   = 3'd5,
        REG_DILATION = 3'd6
    } reg_idx_t;

    localparam int REG_IDX_W = 3;

    // precompute unit to walker
    typedef struct packed {
        logic busy;
        logic too_large;
    } geom_status_t;

    // APB data width: 64 once a packed dimension register passes 32 bits
    function automatic int apb_data_w(input int dim_bits);
        return (3 * dim_bits > 32) ? 64 : 32;
    endfunction

    // byte offset bits below the register index
    function automatic int apb_shift(input int dim_bits);
        return (3 * dim_bits > 32) ? 3 : 2;
    endfunction

endpackage

>>> hw/rtl/dvaw_regs.sv
`timescale 1ns / 1ps

module dvaw_regs #(
    parameter int DIM_BITS    = dvaw_pkg::DIM_BITS_DEF,
    parameter int KERNEL_BITS = dvaw_pkg::KERNEL_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [dvaw_pkg::REG_IDX_W+dvaw_pkg::apb_shift(DIM_BITS)-1:0] paddr,
    input  logic [dvaw_pkg::apb_data_w(DIM_BITS)-1:0]     pwdata,
    output logic [dvaw_pkg::apb_data_w(DIM_BITS)-1:0]     prdata,
    output logic                                          pready,
    output logic                                          cfg_wr,
    output logic [DIM_BITS-1:0]                           cfg_channels,
    output logic [3*DIM_BITS-1:0]                         cfg_vol_dims,
    output logic [3*DIM_BITS-1:0]                         cfg_col_dims,
    output logic [3*KERNEL_BITS-1:0]                      cfg_kernel_dims,
    output logic [3*dvaw_pkg::PAD_BITS-1:0]               cfg_pad_dims,
    output logic [3*dvaw_pkg::STEP_BITS-1:0]              cfg_stride_dims,
    output logic [3*dvaw_pkg::STEP_BITS-1:0]              cfg_dilation_dims
);

    localparam int PDATA_W = dvaw_pkg::apb_data_w(DIM_BITS);
    localparam int ASH     = dvaw_pkg::apb_shift(DIM_BITS);
    localparam int PADDR_W = dvaw_pkg::REG_IDX_W + ASH;

    logic [DIM_BITS-1:0]                 channels_reg;
    logic [3*DIM_BITS-1:0]               vol_dims_reg;
    logic [3*DIM_BITS-1:0]               col_dims_reg;
    logic [3*KERNEL_BITS-1:0]            kernel_dims_reg;
    logic [3*dvaw_pkg::PAD_BITS-1:0]     pad_dims_reg;
    logic [3*dvaw_pkg::STEP_BITS-1:0]    stride_dims_reg;
    logic [3*dvaw_pkg::STEP_BITS-1:0]    dilation_dims_reg;
    dvaw_pkg::reg_idx_t                  idx;

    assign pready = 1'b1;
    assign idx    = dvaw_pkg::reg_idx_t'(paddr[PADDR_W-1:ASH]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg      <= DIM_BITS'(1);
            vol_dims_reg      <= {3{DIM_BITS'(1)}};
            col_dims_reg      <= {3{DIM_BITS'(1)}};
            kernel_dims_reg   <= {3{KERNEL_BITS'(1)}};
            pad_dims_reg      <= '0;
            stride_dims_reg   <= {3{dvaw_pkg::STEP_BITS'(1)}};
            dilation_dims_reg <= {3{dvaw_pkg::STEP_BITS'(1)}};
        end else if (cfg_wr) begin
            case (idx)
                dvaw_pkg::REG_CHANNELS: channels_reg    <= pwdata[DIM_BITS-1:0];
                dvaw_pkg::REG_VOL_DIMS: vol_dims_reg    <= pwdata[3*DIM_BITS-1:0];
                dvaw_pkg::REG_COL_DIMS: col_dims_reg    <= pwdata[3*DIM_BITS-1:0];
                dvaw_pkg::REG_KERNEL:   kernel_dims_reg <= pwdata[3*KERNEL_BITS-1:0];
                dvaw_pkg::REG_PAD:      pad_dims_reg    <= pwdata[3*dvaw_pkg::PAD_BITS-1:0];
                dvaw_pkg::REG_STRIDE: begin
                    stride_dims_reg <= pwdata[3*dvaw_pkg::STEP_BITS-1:0];
                end
                dvaw_pkg::REG_DILATION: begin
                    dilation_dims_reg <= pwdata[3*dvaw_pkg::STEP_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            dvaw_pkg::REG_CHANNELS: prdata = PDATA_W'(channels_reg);
            dvaw_pkg::REG_VOL_DIMS: prdata = PDATA_W'(vol_dims_reg);
            dvaw_pkg::REG_COL_DIMS: prdata = PDATA_W'(col_dims_reg);
            dvaw_pkg::REG_KERNEL:   prdata = PDATA_W'(kernel_dims_reg);
            dvaw_pkg::REG_PAD:      prdata = PDATA_W'(pad_dims_reg);
            dvaw_pkg::REG_STRIDE:   prdata = PDATA_W'(stride_dims_reg);
            dvaw_pkg::REG_DILATION: prdata = PDATA_W'(dilation_dims_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg_channels      = channels_reg;
    assign cfg_vol_dims      = vol_dims_reg;
    assign cfg_col_dims      = col_dims_reg;
    assign cfg_kernel_dims   = kernel_dims_reg;
    assign cfg_pad_dims      = pad_dims_reg;
    assign cfg_stride_dims   = stride_dims_reg;
    assign cfg_dilation_dims = dilation_dims_reg;

endmodule

>>> hw/rtl/dvaw_geom.sv
`timescale 1ns / 1ps

module dvaw_geom #(
    parameter int DIM_BITS    = dvaw_pkg::DIM_BITS_DEF,
    parameter int KERNEL_BITS = dvaw_pkg::KERNEL_BITS_DEF,
    parameter int ADDR_BITS   = dvaw_pkg::ADDR_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr,
    input  logic [DIM_BITS-1:0]          cfg_channels,
    input  logic [3*DIM_BITS-1:0]        cfg_vol_dims,
    input  logic [3*DIM_BITS-1:0]        cfg_col_dims,
    input  logic [3*KERNEL_BITS-1:0]     cfg_kernel_dims,
    output dvaw_pkg::geom_status_t       status
);

    localparam int FW     = (DIM_BITS > KERNEL_BITS) ? DIM_BITS : KERNEL_BITS;
    localparam int PW     = ADDR_BITS + 1 + FW;
    localparam int STEP_W = $clog2(dvaw_pkg::GEOM_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(dvaw_pkg::GEOM_STEPS - 1);
    // 2^ADDR_BITS is the largest legal count; one above it marks overflow
    localparam logic [ADDR_BITS:0] CAP      = {1'b1, {ADDR_BITS{1'b0}}};
    localparam logic [ADDR_BITS:0] CAP_OVER = CAP + (ADDR_BITS+1)'(1);

    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [ADDR_BITS:0]   ccount_reg;
    logic [ADDR_BITS:0]   vcount_reg;
    logic [FW-1:0]        fc;
    logic [FW-1:0]        fv;

    function automatic logic [ADDR_BITS:0] sat_mul(input logic [ADDR_BITS:0] a,
                                                   input logic [FW-1:0] f);
        logic [PW-1:0] p;
        p = PW'(a) * PW'(f);
        return (p > PW'(CAP)) ? CAP_OVER : p[ADDR_BITS:0];
    endfunction

    // factor per pass; fields: width lowest, depth highest
    always_comb begin
        case (step_reg)
            STEP_W'(0): begin
                fc = FW'(cfg_channels);
                fv = FW'(cfg_channels);
            end
            STEP_W'(1): begin
                fc = FW'(cfg_kernel_dims[2*KERNEL_BITS +: KERNEL_BITS]);
                fv = FW'(cfg_vol_dims[2*DIM_BITS +: DIM_BITS]);
            end
            STEP_W'(2): begin
                fc = FW'(cfg_kernel_dims[KERNEL_BITS +: KERNEL_BITS]);
                fv = FW'(cfg_vol_dims[DIM_BITS +: DIM_BITS]);
            end
            STEP_W'(3): begin
                fc = FW'(cfg_kernel_dims[0 +: KERNEL_BITS]);
                fv = FW'(cfg_vol_dims[0 +: DIM_BITS]);
            end
            STEP_W'(4): begin
                fc = FW'(cfg_col_dims[2*DIM_BITS +: DIM_BITS]);
                fv = FW'(1);
            end
            STEP_W'(5): begin
                fc = FW'(cfg_col_dims[DIM_BITS +: DIM_BITS]);
                fv = FW'(1);
            end
            STEP_W'(6): begin
                fc = FW'(cfg_col_dims[0 +: DIM_BITS]);
                fv = FW'(1);
            end
            default: begin
                fc = FW'(1);
                fv = FW'(1);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            busy_reg   <= 1'b1;
            step_reg   <= '0;
            ccount_reg <= (ADDR_BITS+1)'(1);
            vcount_reg <= (ADDR_BITS+1)'(1);
        end else if (busy_reg) begin
            ccount_reg <= sat_mul(ccount_reg, fc);
            vcount_reg <= sat_mul(vcount_reg, fv);
            step_reg   <= step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign status.busy      = busy_reg;
    assign status.too_large = (ccount_reg > CAP) || (vcount_reg > CAP);

endmodule

>>> hw/rtl/dvaw_front.sv
`timescale 1ns / 1ps

module dvaw_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dvaw_pkg::S_TDATA_W-1:0] s_tdata,   // [0] start_req
    input  logic                           q_pop,
    output logic                           q_valid,
    output logic                           q_start
);

    localparam int DEPTH   = 2;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign s_tready = (count_reg != COUNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_start  = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + COUNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/dvaw_back.sv
`timescale 1ns / 1ps

module dvaw_back #(
    parameter int DIM_BITS    = dvaw_pkg::DIM_BITS_DEF,
    parameter int KERNEL_BITS = dvaw_pkg::KERNEL_BITS_DEF,
    parameter int ADDR_BITS   = dvaw_pkg::ADDR_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [DIM_BITS-1:0]               cfg_channels,
    input  logic [3*DIM_BITS-1:0]             cfg_vol_dims,
    input  logic [3*DIM_BITS-1:0]             cfg_col_dims,
    input  logic [3*KERNEL_BITS-1:0]          cfg_kernel_dims,
    input  logic [3*dvaw_pkg::PAD_BITS-1:0]   cfg_pad_dims,
    input  logic [3*dvaw_pkg::STEP_BITS-1:0]  cfg_stride_dims,
    input  logic [3*dvaw_pkg::STEP_BITS-1:0]  cfg_dilation_dims,
    input  dvaw_pkg::geom_status_t            geom,
    input  logic                              q_valid,
    input  logic                              q_start,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ADDR_BITS-1:0]              m_col_addr,
    output logic [ADDR_BITS-1:0]              m_vol_addr,
    output logic                              m_in_window,
    output logic                              m_last,
    output logic                              m_too_large
);

    localparam int PB  = dvaw_pkg::PAD_BITS;
    localparam int SB  = dvaw_pkg::STEP_BITS;
    localparam int SW  = ((DIM_BITS > KERNEL_BITS) ? DIM_BITS : KERNEL_BITS) + SB + 2;
    localparam int DW1 = DIM_BITS + 1;
    localparam int KW1 = KERNEL_BITS + 1;
    localparam int M1W = (2 * DIM_BITS + 1 > ADDR_BITS) ? 2 * DIM_BITS + 1 : ADDR_BITS;
    localparam int M2W = ADDR_BITS + DIM_BITS + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_AXIS  = 5'b00010,
        ST_MUL_D = 5'b00100,
        ST_MUL_H = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // walk position; axis 0 = width, 2 = depth
    logic [DIM_BITS-1:0]               chan_reg, chan_next, chan_adv;
    logic [2:0][KERNEL_BITS-1:0]       koff_reg, koff_next, koff_adv;
    logic [2:0][DIM_BITS-1:0]          pos_reg, pos_next, pos_adv;
    logic [ADDR_BITS-1:0]              col_idx_reg, col_idx_next, col_idx_adv;

    // per-item work
    logic                              empty_reg;
    logic                              inside_reg;
    logic                              last_reg;
    logic [2:0][DIM_BITS-1:0]          coord_reg;
    logic [ADDR_BITS-1:0]              acc_reg;

    // result slot
    logic                              m_tvalid_reg;
    logic [ADDR_BITS-1:0]              col_out_reg;
    logic [ADDR_BITS-1:0]              vol_out_reg;
    logic                              in_out_reg;
    logic                              last_out_reg;
    logic                              tl_out_reg;

    logic [2:0][DIM_BITS-1:0]          vdim;
    logic [2:0][DIM_BITS-1:0]          cdim;
    logic [2:0][KERNEL_BITS-1:0]       kdim;
    logic [2:0][PB-1:0]                pad;
    logic [2:0][SB-1:0]                stride;
    logic [2:0][SB-1:0]                dil;
    logic [2:0][SW-1:0]                ax_val;
    logic [2:0]                        ax_in;
    logic                              cfg_empty;
    logic                              last_c;
    logic                              out_load;
    logic [M1W-1:0]                    m1;
    logic [M2W-1:0]                    m2;
    logic [M2W-1:0]                    m3;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vdim[k]   = cfg_vol_dims[k*DIM_BITS +: DIM_BITS];
            cdim[k]   = cfg_col_dims[k*DIM_BITS +: DIM_BITS];
            kdim[k]   = cfg_kernel_dims[k*KERNEL_BITS +: KERNEL_BITS];
            pad[k]    = cfg_pad_dims[k*PB +: PB];
            stride[k] = cfg_stride_dims[k*SB +: SB];
            dil[k]    = cfg_dilation_dims[k*SB +: SB];
        end
    end

    assign cfg_empty = (cfg_channels == '0)
                    || (kdim[0] == '0) || (kdim[1] == '0) || (kdim[2] == '0)
                    || (cdim[0] == '0) || (cdim[1] == '0) || (cdim[2] == '0);

    // padded coordinate per axis; a negative value wraps high and fails the bound
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ax_val[k] = SW'(pos_reg[k]) * SW'(stride[k])
                      + SW'(koff_reg[k]) * SW'(dil[k])
                      - SW'(pad[k]);
            ax_in[k]  = ax_val[k] < SW'(vdim[k]);
        end
    end

    always_comb begin
        last_c = (chan_reg == cfg_channels - DIM_BITS'(1));
        for (int k = 0; k < 3; k++) begin
            last_c = last_c
                  && (koff_reg[k] == kdim[k] - KERNEL_BITS'(1))
                  && (pos_reg[k] == cdim[k] - DIM_BITS'(1));
        end
    end

    // advance: innermost width position first, channel last
    always_comb begin
        logic carry;
        carry    = 1'b1;
        pos_adv  = pos_reg;
        koff_adv = koff_reg;
        chan_adv = chan_reg;
        for (int k = 0; k < 3; k++) begin
            if (carry) begin
                if (DW1'(pos_reg[k]) + DW1'(1) >= DW1'(cdim[k])) begin
                    pos_adv[k] = '0;
                end else begin
                    pos_adv[k] = pos_reg[k] + DIM_BITS'(1);
                    carry      = 1'b0;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (carry) begin
                if (KW1'(koff_reg[k]) + KW1'(1) >= KW1'(kdim[k])) begin
                    koff_adv[k] = '0;
                end else begin
                    koff_adv[k] = koff_reg[k] + KERNEL_BITS'(1);
                    carry       = 1'b0;
                end
            end
        end
        if (carry) begin
            if (DW1'(chan_reg) + DW1'(1) >= DW1'(cfg_channels)) begin
                chan_adv = '0;
            end else begin
                chan_adv = chan_reg + DIM_BITS'(1);
                carry    = 1'b0;
            end
        end
        col_idx_adv = carry ? '0 : col_idx_reg + ADDR_BITS'(1);
    end

    always_comb begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        koff_next    = koff_reg;
        pos_next     = pos_reg;
        col_idx_next = col_idx_reg;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !geom.busy) begin
                    q_pop = 1'b1;
                    if (cfg_empty) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_AXIS;
                        if (q_start) begin
                            chan_next    = '0;
                            koff_next    = '0;
                            pos_next     = '0;
                            col_idx_next = '0;
                        end
                    end
                end
            end
            ST_AXIS:  state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_MUL_H;
            ST_MUL_H: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (!empty_reg) begin
                        chan_next    = chan_adv;
                        koff_next    = koff_adv;
                        pos_next     = pos_adv;
                        col_idx_next = col_idx_adv;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // volume index, one multiply per step: ((c*D + tp)*H + hp)*W + wp
    assign m1 = M1W'(chan_reg) * M1W'(vdim[2]) + M1W'(coord_reg[2]);
    assign m2 = M2W'(acc_reg) * M2W'(vdim[1]) + M2W'(coord_reg[1]);
    assign m3 = M2W'(acc_reg) * M2W'(vdim[0]) + M2W'(coord_reg[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_reg     <= '0;
            koff_reg     <= '0;
            pos_reg      <= '0;
            col_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            koff_reg    <= koff_next;
            pos_reg     <= pos_next;
            col_idx_reg <= col_idx_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            empty_reg <= cfg_empty;
        end
        if (state_reg == ST_AXIS) begin
            inside_reg <= &ax_in;
            last_reg   <= last_c;
            for (int k = 0; k < 3; k++) begin
                coord_reg[k] <= ax_val[k][DIM_BITS-1:0];
            end
        end
        if (state_reg == ST_MUL_D) begin
            acc_reg <= m1[ADDR_BITS-1:0];
        end
        if (state_reg == ST_MUL_H) begin
            acc_reg <= m2[ADDR_BITS-1:0];
        end
        if (out_load) begin
            col_out_reg  <= empty_reg ? '0 : col_idx_reg;
            vol_out_reg  <= (empty_reg || !inside_reg) ? '0 : m3[ADDR_BITS-1:0];
            in_out_reg   <= !empty_reg && inside_reg;
            last_out_reg <= empty_reg || last_reg;
            tl_out_reg   <= geom.too_large;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_col_addr  = col_out_reg;
    assign m_vol_addr  = vol_out_reg;
    assign m_in_window = in_out_reg;
    assign m_last      = last_out_reg;
    assign m_too_large = tl_out_reg;

`ifndef SYNTHESIS
    a_no_start_while_precompute: assert property (
        @(posedge aclk) disable iff (!aresetn) geom.busy |-> !q_pop
    ) else $error("item taken while overflow check still running");

    a_pop_needs_item: assert property (
        @(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid
    ) else $error("pop from empty queue");

    a_outside_is_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !in_out_reg) |-> (vol_out_reg == '0)
    ) else $error("volume index not zero outside window");

    a_restart_clears: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (q_pop && q_start && !cfg_empty) |=> (col_idx_reg == '0 && chan_reg == '0)
    ) else $error("restart did not clear the walk");
`endif

endmodule

>>> hw/rtl/dilated_vol2col_address_walk.sv
`timescale 1ns / 1ps
// With a ready sink, an input transaction passes the queue pop, axis coordinates, depth and
//   height multiply steps and the width multiply into the output register.
// Steps are taken one at a time; each runs the three-step volume index multiply chain before
//   the next is popped, and a step on an empty walk skips the chain. Input queue holds 2 steps.
// After reset and after any register write, an overflow-check pass runs; no step starts meanwhile.
// Reset: aresetn synchronous, active low; registers to defaults, walk at element 0, queue empty.
module dilated_vol2col_address_walk #(
    parameter int DIM_BITS    = dvaw_pkg::DIM_BITS_DEF,
    parameter int KERNEL_BITS = dvaw_pkg::KERNEL_BITS_DEF,
    parameter int ADDR_BITS   = dvaw_pkg::ADDR_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // step input
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [dvaw_pkg::S_TDATA_W-1:0]             s_tdata,   // [0] start_req
    // address output
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [((2*ADDR_BITS+7)/8)*8-1:0]           m_tdata,   // col_addr, vol_addr
    output logic                                       m_tlast,   // last
    output logic [dvaw_pkg::M_TUSER_W-1:0]             m_tuser,   // in_window, too_large
    // register port
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [dvaw_pkg::REG_IDX_W+dvaw_pkg::apb_shift(DIM_BITS)-1:0] paddr,
    input  logic [dvaw_pkg::apb_data_w(DIM_BITS)-1:0]  pwdata,
    output logic [dvaw_pkg::apb_data_w(DIM_BITS)-1:0]  prdata,
    output logic                                       pready
);

    localparam int TDATA_W = ((2 * ADDR_BITS + 7) / 8) * 8;

    logic                                   cfg_wr;
    logic [DIM_BITS-1:0]                    cfg_channels;
    logic [3*DIM_BITS-1:0]                  cfg_vol_dims;
    logic [3*DIM_BITS-1:0]                  cfg_col_dims;
    logic [3*KERNEL_BITS-1:0]               cfg_kernel_dims;
    logic [3*dvaw_pkg::PAD_BITS-1:0]        cfg_pad_dims;
    logic [3*dvaw_pkg::STEP_BITS-1:0]       cfg_stride_dims;
    logic [3*dvaw_pkg::STEP_BITS-1:0]       cfg_dilation_dims;
    dvaw_pkg::geom_status_t                 geom;
    logic                                   q_valid;
    logic                                   q_start;
    logic                                   q_pop;
    logic [ADDR_BITS-1:0]                   col_addr;
    logic [ADDR_BITS-1:0]                   vol_addr;
    logic                                   in_window;
    logic                                   too_large;

    // register file behind the APB port
    dvaw_regs #(
        .DIM_BITS    (DIM_BITS),
        .KERNEL_BITS (KERNEL_BITS)
    ) u_regs (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .cfg_wr            (cfg_wr),
        .cfg_channels      (cfg_channels),
        .cfg_vol_dims      (cfg_vol_dims),
        .cfg_col_dims      (cfg_col_dims),
        .cfg_kernel_dims   (cfg_kernel_dims),
        .cfg_pad_dims      (cfg_pad_dims),
        .cfg_stride_dims   (cfg_stride_dims),
        .cfg_dilation_dims (cfg_dilation_dims)
    );

    // element-count overflow flag, refreshed after each write by a
    // saturating multiply per cycle
    dvaw_geom #(
        .DIM_BITS    (DIM_BITS),
        .KERNEL_BITS (KERNEL_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_geom (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr          (cfg_wr),
        .cfg_channels    (cfg_channels),
        .cfg_vol_dims    (cfg_vol_dims),
        .cfg_col_dims    (cfg_col_dims),
        .cfg_kernel_dims (cfg_kernel_dims),
        .status          (geom)
    );

    // front: takes step transactions into a short queue
    dvaw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_start  (q_start)
    );

    // back: walk counters, address arithmetic and the output register
    dvaw_back #(
        .DIM_BITS    (DIM_BITS),
        .KERNEL_BITS (KERNEL_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_channels      (cfg_channels),
        .cfg_vol_dims      (cfg_vol_dims),
        .cfg_col_dims      (cfg_col_dims),
        .cfg_kernel_dims   (cfg_kernel_dims),
        .cfg_pad_dims      (cfg_pad_dims),
        .cfg_stride_dims   (cfg_stride_dims),
        .cfg_dilation_dims (cfg_dilation_dims),
        .geom              (geom),
        .q_valid           (q_valid),
        .q_start           (q_start),
        .q_pop             (q_pop),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_col_addr        (col_addr),
        .m_vol_addr        (vol_addr),
        .m_in_window       (in_window),
        .m_last            (m_tlast),
        .m_too_large       (too_large)
    );

    // col_addr lowest, vol_addr above, zero fill to a whole byte
    assign m_tdata = TDATA_W'({vol_addr, col_addr});
    assign m_tuser = {too_large, in_window};

endmodule
